// File: design/assert_macros.svh
// assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CRRD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRRD_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CRRD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRRD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// File: design/crrd_pkg.sv
// types, constants and the arctangent table of the circle/rotated-rectangle test
package crrd_pkg;
  localparam int GUARD       = 4;
  localparam int CW          = 31;
  localparam int ZW          = 33;
  localparam int MAX_STAGES  = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam logic signed [30:0] INV_GAIN = 31'sd652032874;
  localparam logic [23:0] DIST_MAX = 24'hFFFFFF;

  // word handed from front to back
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic signed [23:0]   x0;
    logic signed [23:0]   y0;
    logic signed [23:0]   x1;
    logic signed [23:0]   y1;
    logic [22:0]          rad;
  } rot_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

// File: design/crrd_if.sv
// valid/ready channels for test items and results
interface crrd_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] center_x;
  logic signed [23:0] center_y;
  logic [22:0]        circle_radius;
  logic signed [23:0] rect_min_x;
  logic signed [23:0] rect_min_y;
  logic signed [23:0] rect_max_x;
  logic signed [23:0] rect_max_y;
  logic signed [15:0] rect_angle;
  modport source (output valid, center_x, center_y, circle_radius, rect_min_x,
                  rect_min_y, rect_max_x, rect_max_y, rect_angle, input ready);
  modport sink (input valid, center_x, center_y, circle_radius, rect_min_x,
                rect_min_y, rect_max_x, rect_max_y, rect_angle, output ready);
endinterface

interface crrd_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] distance;
  logic        hit;
  modport source (output valid, distance, hit, input ready);
  modport sink (input valid, distance, hit, output ready);
endinterface

// File: design/crrd_front.sv
// front end: midpoint offset, inverse-gain prescale and quadrant fold
module crrd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  crrd_in_if.sink         item_i,
  input  logic            full_i,
  output logic            push_o,
  output crrd_pkg::rot_t  push_data_o
);
  import crrd_pkg::*;

  logic en;
  logic a_v_q, b_v_q;
  logic signed [28:0] a_dx_q, a_dy_q;
  logic signed [ZW-1:0] a_z_q, b_z_q;
  logic a_flip_q, b_flip_q;
  logic signed [23:0] a_x0_q, a_y0_q, a_x1_q, a_y1_q;
  logic signed [23:0] b_x0_q, b_y0_q, b_x1_q, b_y1_q;
  logic [22:0] a_rad_q, b_rad_q;
  logic signed [59:0] b_px_q, b_py_q;

  logic signed [24:0] sx, sy;
  logic signed [28:0] dx_d, dy_d;
  logic [15:0] nang;
  logic signed [31:0] z32;
  logic signed [ZW-1:0] z_d;
  logic flip_d;
  logic signed [59:0] rx, ry;
  logic signed [CW-1:0] xr, yr;

  assign en = !full_i;
  assign item_i.ready = en;

  always_comb begin
    sx = 25'(item_i.rect_min_x) + 25'(item_i.rect_max_x);
    sy = 25'(item_i.rect_min_y) + 25'(item_i.rect_max_y);
    dx_d = (29'(item_i.center_x) <<< GUARD) - (29'(sx) <<< (GUARD - 1));
    dy_d = (29'(item_i.center_y) <<< GUARD) - (29'(sy) <<< (GUARD - 1));
    nang = 16'd0 - item_i.rect_angle;
    z32 = {nang, 16'd0};
    flip_d = 1'b0;
    z_d = ZW'(z32);
    // fold angles beyond a quarter turn by a half turn and negate the vector
    if (z32 > 32'sh40000000) begin
      flip_d = 1'b1;
      z_d = ZW'(z32) - 33'sh080000000;
    end else if (z32 < -32'sh40000000) begin
      flip_d = 1'b1;
      z_d = ZW'(z32) + 33'sh080000000;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= item_i.valid;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q   <= dx_d;
      a_dy_q   <= dy_d;
      a_z_q    <= z_d;
      a_flip_q <= flip_d;
      a_x0_q   <= item_i.rect_min_x;
      a_y0_q   <= item_i.rect_min_y;
      a_x1_q   <= item_i.rect_max_x;
      a_y1_q   <= item_i.rect_max_y;
      a_rad_q  <= item_i.circle_radius;
      b_px_q   <= 60'(a_dx_q) * 60'(INV_GAIN);
      b_py_q   <= 60'(a_dy_q) * 60'(INV_GAIN);
      b_z_q    <= a_z_q;
      b_flip_q <= a_flip_q;
      b_x0_q   <= a_x0_q;
      b_y0_q   <= a_y0_q;
      b_x1_q   <= a_x1_q;
      b_y1_q   <= a_y1_q;
      b_rad_q  <= a_rad_q;
    end
  end

  always_comb begin
    rx = b_px_q + 60'sh20000000;
    ry = b_py_q + 60'sh20000000;
    xr = CW'($signed(rx[59:30]));
    yr = CW'($signed(ry[59:30]));
    push_data_o.x   = b_flip_q ? -xr : xr;
    push_data_o.y   = b_flip_q ? -yr : yr;
    push_data_o.z   = b_z_q;
    push_data_o.x0  = b_x0_q;
    push_data_o.y0  = b_y0_q;
    push_data_o.x1  = b_x1_q;
    push_data_o.y1  = b_y1_q;
    push_data_o.rad = b_rad_q;
  end

  assign push_o = b_v_q && en;
endmodule

// File: design/crrd_queue.sv
// short flop queue between front and back
module crrd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  crrd_pkg::rot_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output crrd_pkg::rot_t  head_o,
  output logic            empty_o
);
  import crrd_pkg::*;
`include "assert_macros.svh"

  rot_t mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0] cnt_q;

  assign full_o  = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  `CRRD_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `CRRD_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `CRRD_ASSERT(a_cnt_ptr, clk_i, rst_ni, (wr_q - rd_q) == cnt_q[QPTR_W-1:0], "count off")
endmodule

// File: design/crrd_back.sv
// back end: cordic rotation, clamp, squared distance, pipelined square root
module crrd_back #(
  parameter int ROTATE_STAGES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  crrd_pkg::rot_t  head_i,
  input  logic            empty_i,
  output logic            pop_o,
  crrd_out_if.source      result_o
);
  import crrd_pkg::*;
`include "assert_macros.svh"

  localparam int NS = (ROTATE_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATE_STAGES;
  localparam int SQ = 32;

  logic en;
  logic out_v_q;
  logic [23:0] dist_q;
  logic hit_q;

  rot_t c_q [NS+1];
  logic c_v_q [NS+1];

  logic e_v_q;
  logic [31:0] ex_q, ey_q;
  logic [22:0] e_rad_q;
  logic m_v_q;
  logic [63:0] mx_q, my_q;
  logic [22:0] m_rad_q;

  logic s_v_q [SQ+1];
  logic [63:0] s_n_q [SQ+1];
  logic [33:0] s_rem_q [SQ+1];
  logic [31:0] s_root_q [SQ+1];
  logic [22:0] s_rad_q [SQ+1];

  assign en = !out_v_q || result_o.ready;
  assign pop_o = en && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_v_q[0] <= 1'b0;
    else if (en) c_v_q[0] <= !empty_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) c_q[0] <= head_i;
  end

  for (genvar i = 0; i < NS; i++) begin : g_rot
    rot_t nx;
    always_comb begin
      nx = c_q[i];
      if (!c_q[i].z[ZW-1]) begin
        nx.x = c_q[i].x - (c_q[i].y >>> i);
        nx.y = c_q[i].y + (c_q[i].x >>> i);
        nx.z = c_q[i].z - atan_lut(5'(i));
      end else begin
        nx.x = c_q[i].x + (c_q[i].y >>> i);
        nx.y = c_q[i].y - (c_q[i].x >>> i);
        nx.z = c_q[i].z + atan_lut(5'(i));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) c_v_q[i+1] <= 1'b0;
      else if (en) c_v_q[i+1] <= c_v_q[i];
    end
    always_ff @(posedge clk_i) begin
      if (en) c_q[i+1] <= nx;
    end
  end

  // clamp the rotated point into the rectangle, min checked first
  logic signed [33:0] px, py, lox, hix, loy, hiy, clx, cly, dx, dy;
  always_comb begin
    px  = (34'(c_q[NS].x0) + 34'(c_q[NS].x1)) * 34'sd8 + 34'(c_q[NS].x);
    py  = (34'(c_q[NS].y0) + 34'(c_q[NS].y1)) * 34'sd8 + 34'(c_q[NS].y);
    lox = 34'(c_q[NS].x0) <<< GUARD;
    hix = 34'(c_q[NS].x1) <<< GUARD;
    loy = 34'(c_q[NS].y0) <<< GUARD;
    hiy = 34'(c_q[NS].y1) <<< GUARD;
    clx = (px < lox) ? lox : ((px > hix) ? hix : px);
    cly = (py < loy) ? loy : ((py > hiy) ? hiy : py);
    dx  = px - clx;
    dy  = py - cly;
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
      m_v_q <= 1'b0;
      s_v_q[0] <= 1'b0;
    end else if (en) begin
      e_v_q <= c_v_q[NS];
      m_v_q <= e_v_q;
      s_v_q[0] <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ex_q        <= dx[31:0];
      ey_q        <= dy[31:0];
      e_rad_q     <= c_q[NS].rad;
      mx_q        <= 64'(ex_q) * 64'(ex_q);
      my_q        <= 64'(ey_q) * 64'(ey_q);
      m_rad_q     <= e_rad_q;
      s_n_q[0]    <= mx_q + my_q;
      s_rem_q[0]  <= '0;
      s_root_q[0] <= '0;
      s_rad_q[0]  <= m_rad_q;
    end
  end

  // one result bit per stage, restoring digit recurrence
  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [35:0] rs, tr, df;
    logic ge;
    always_comb begin
      rs = {s_rem_q[k], s_n_q[k][63:62]};
      tr = {2'b00, s_root_q[k], 2'b01};
      df = rs - tr;
      ge = (rs >= tr);
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) s_v_q[k+1] <= 1'b0;
      else if (en) s_v_q[k+1] <= s_v_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        s_n_q[k+1]    <= {s_n_q[k][61:0], 2'b00};
        s_rem_q[k+1]  <= ge ? df[33:0] : rs[33:0];
        s_root_q[k+1] <= {s_root_q[k][30:0], ge};
        s_rad_q[k+1]  <= s_rad_q[k];
      end
    end
  end

  logic [32:0] rnd;
  logic [28:0] dfull;
  logic [23:0] dsat;
  always_comb begin
    rnd   = 33'(s_root_q[SQ]) + 33'(1 << (GUARD - 1));
    dfull = rnd[32:GUARD];
    dsat  = (dfull > 29'(DIST_MAX)) ? DIST_MAX : dfull[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= s_v_q[SQ];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dsat;
      hit_q  <= (dsat < 24'(s_rad_q[SQ]));
    end
  end

  assign result_o.valid    = out_v_q;
  assign result_o.distance = dist_q;
  assign result_o.hit      = hit_q;

  `CRRD_ASSERT(a_hold_stall, clk_i, rst_ni, !en |=> $stable(s_v_q[SQ]) && $stable(c_v_q[NS]), "pipe moved in stall")
  `CRRD_ASSERT(a_pop_enters, clk_i, rst_ni, pop_o |=> c_v_q[0], "popped word lost")
  `CRRD_NEVER(a_stall_only_full, clk_i, rst_ni, !en && !out_v_q, "stall without pending word")
endmodule

// File: design/circle_rotated_rect_distance_core.sv
// path from accept to result valid: front registers a and b, the queue memory, then the back's
//   input register, cordic stages, e, m and s[0] registers, square-root stages and output register
// throughput: one test per cycle; front and back each stall on their own, a 4-word queue
//   between them absorbs a stalled result sink
// a stage-per-iteration cordic and a one-bit-per-stage square root set the latency
// reset: asynchronous active-low rst_ni clears all valid bits and the queue pointers
module circle_rotated_rect_distance_core #(
  parameter int ROTATE_STAGES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crrd_in_if.sink    item_i,
  crrd_out_if.source result_o
);
  import crrd_pkg::*;

  logic push, full, pop, empty;
  rot_t push_data, head;

  crrd_front u_front (
    .clk_i, .rst_ni, .item_i,
    .full_i(full), .push_o(push), .push_data_o(push_data)
  );

  crrd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .head_o(head), .empty_o(empty)
  );

  crrd_back #(.ROTATE_STAGES(ROTATE_STAGES)) u_back (
    .clk_i, .rst_ni,
    .head_i(head), .empty_i(empty), .pop_o(pop), .result_o
  );
endmodule

// File: tb/circle_rotated_rect_distance_core_tb.sv
// testbench of the circle/rotated-rectangle distance core: random and directed tests, self-checking
`timescale 1ns / 100ps

module circle_rotated_rect_distance_core_tb;
  localparam int N_RANDOM    = 550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN       = 150;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [22:0]        rad;
    logic signed [23:0] x0;
    logic signed [23:0] y0;
    logic signed [23:0] x1;
    logic signed [23:0] y1;
    logic signed [15:0] ang;
  } test_item_t;

  typedef struct {
    logic [23:0] distance;
    logic        hit;
  } dist_result_t;

  localparam longint ARCTAN_TURN32 [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   errors = 0;
  int   items_sent = 0;

  test_item_t   pending_items[$];
  dist_result_t expected_dist[$];

  crrd_in_if  item_if ();
  crrd_out_if res_if ();

  circle_rotated_rect_distance_core #(.ROTATE_STAGES(16)) u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if),
    .result_o(res_if)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL circle_rotated_rect_distance_core");
      $finish;
    end
  end

  function automatic dist_result_t predict_distance(test_item_t it);
    longint mxg, myg, x, y, z, xs, ys, px, py, lo, hi, ex, ey, cl;
    logic [15:0] nang;
    logic [31:0] za;
    longint unsigned sum, root, bitv, dval;
    dist_result_t r;
    nang = -it.ang;
    za = {nang, 16'h0000};
    z = longint'($signed(za));
    mxg = (longint'(it.x0) + longint'(it.x1)) * 8;
    myg = (longint'(it.y0) + longint'(it.y1)) * 8;
    x = ((longint'(it.cx) * 16 - mxg) * 652032874 + (64'sd1 <<< 29)) >>> 30;
    y = ((longint'(it.cy) * 16 - myg) * 652032874 + (64'sd1 <<< 29)) >>> 30;
    if (z > (64'sd1 <<< 30)) begin
      x = -x; y = -y; z = z - (64'sd1 <<< 31);
    end else if (z < -(64'sd1 <<< 30)) begin
      x = -x; y = -y; z = z + (64'sd1 <<< 31);
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ARCTAN_TURN32[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ARCTAN_TURN32[i];
      end
    end
    px = mxg + x;
    py = myg + y;
    // lower bound checked first, so with a min above max a point below min clamps to min, any other to max
    lo = longint'(it.x0) * 16; hi = longint'(it.x1) * 16;
    cl = (px < lo) ? lo : ((px > hi) ? hi : px);
    ex = px - cl;
    lo = longint'(it.y0) * 16; hi = longint'(it.y1) * 16;
    cl = (py < lo) ? lo : ((py > hi) ? hi : py);
    ey = py - cl;
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    sum = longint'(unsigned'(ex)) * unsigned'(ex) + longint'(unsigned'(ey)) * unsigned'(ey);
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > sum) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (sum >= root + bitv) begin
        sum = sum - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    dval = (root + 8) >> 4;
    if (dval > 64'd16777215) dval = 64'd16777215;
    r.distance = dval[23:0];
    r.hit = (dval < {41'd0, it.rad});
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  // signed value spanning roughly 2^s
  function automatic longint rnd_span(int s);
    longint v;
    v = longint'($signed($urandom)) >>> (32 - s);
    return v;
  endfunction

  function automatic test_item_t random_item();
    test_item_t it;
    longint a, b, w, h;
    int s;
    if ($urandom_range(0, 9) == 0) begin
      it.cx = $urandom; it.cy = $urandom; it.rad = $urandom;
      it.x0 = $urandom; it.y0 = $urandom; it.x1 = $urandom; it.y1 = $urandom;
      it.ang = $urandom;
    end else begin
      s = $urandom_range(6, 24);
      a = rnd_span(s);
      b = rnd_span(s);
      w = $urandom_range(0, 1 << (s - 2));
      h = $urandom_range(0, 1 << (s - 2));
      it.x0 = sat24(a); it.x1 = sat24(a + w);
      it.y0 = sat24(b); it.y1 = sat24(b + h);
      it.cx = sat24(a + w / 2 + rnd_span(s - 1));
      it.cy = sat24(b + h / 2 + rnd_span(s - 1));
      it.rad = $urandom_range(0, 1 << (s - 2));
      if ($urandom_range(0, 15) == 0) it.rad = $urandom;
      it.ang = $urandom;
    end
    return it;
  endfunction

  function automatic test_item_t mk(longint cx, longint cy, longint rad, longint x0,
                                    longint y0, longint x1, longint y1, longint ang);
    test_item_t it;
    it.cx = cx; it.cy = cy; it.rad = rad; it.x0 = x0; it.y0 = y0;
    it.x1 = x1; it.y1 = y1; it.ang = ang;
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // driver: bursts of words with random gaps
  int burst_left = 0;
  int gap_left = 0;

  initial begin
    item_if.valid = 1'b0;
    item_if.center_x = '0; item_if.center_y = '0; item_if.circle_radius = '0;
    item_if.rect_min_x = '0; item_if.rect_min_y = '0;
    item_if.rect_max_x = '0; item_if.rect_max_y = '0; item_if.rect_angle = '0;
  end

  always @(posedge clk) begin
    logic nv;
    if (rst_n) begin
      if (item_if.valid && item_if.ready) begin
        expected_dist.push_back(predict_distance(pending_items[0]));
        void'(pending_items.pop_front());
        items_sent <= items_sent + 1;
        if (burst_left > 0) burst_left--;
      end
      if (item_if.valid && !item_if.ready) begin
        nv = 1'b1;
      end else begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left = $urandom_range(0, 6);
        end
        if (gap_left > 0) begin
          gap_left--;
          nv = 1'b0;
        end else begin
          nv = (pending_items.size() > 0);
        end
      end
      item_if.valid <= nv;
      if (nv) begin
        item_if.center_x      <= pending_items[0].cx;
        item_if.center_y      <= pending_items[0].cy;
        item_if.circle_radius <= pending_items[0].rad;
        item_if.rect_min_x    <= pending_items[0].x0;
        item_if.rect_min_y    <= pending_items[0].y0;
        item_if.rect_max_x    <= pending_items[0].x1;
        item_if.rect_max_y    <= pending_items[0].y1;
        item_if.rect_angle    <= pending_items[0].ang;
      end
    end
  end

  // monitor: random stalls plus one long hold-off
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  initial res_if.ready = 1'b0;

  always @(posedge clk) begin
    dist_result_t e;
    logic nr;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_dist.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          e = expected_dist.pop_front();
          if (res_if.distance !== e.distance)
            report_mismatch($sformatf("distance %0d, expected %0d", res_if.distance,
                                      e.distance));
          if (res_if.hit !== e.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", res_if.hit, e.hit));
        end
      end
      if (!hold_done && items_sent >= 200) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if ((cycles / 64) % 3 == 0) begin
        nr = 1'b1;
      end else begin
        nr = ($urandom_range(0, 3) != 0);
      end
      res_if.ready <= nr;
    end
  end

  initial begin
    // extremes, min above max, half-turn angle, quarter turns, zero-size box
    pending_items.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(8388607, 8388607, 8388607, -8388608, -8388608,
                               -8388608, -8388608, 0));
    pending_items.push_back(mk(-8388608, -8388608, 8388607, 8388607, 8388607,
                               8388607, 8388607, -32768));
    pending_items.push_back(mk(8388607, -8388608, 0, 8388607, -8388608,
                               8388607, -8388608, 32767));
    pending_items.push_back(mk(-8388608, 8388607, 1, -8388608, -8388608,
                               8388607, 8388607, 16384));
    pending_items.push_back(mk(1000, 2000, 300, 500, 500, -500, -500, 0));
    pending_items.push_back(mk(-3000, 100, 900, 800, -200, 200, 400, 5000));
    pending_items.push_back(mk(5000, 0, 4000, -1000, -1000, 1000, 1000, -32768));
    pending_items.push_back(mk(5000, 0, 4000, -1000, -1000, 1000, 1000, 16384));
    pending_items.push_back(mk(5000, 0, 4000, -1000, -1000, 1000, 1000, -16384));
    pending_items.push_back(mk(5000, 0, 4000, -1000, -1000, 1000, 1000, 16385));
    pending_items.push_back(mk(5000, 0, 4000, -1000, -1000, 1000, 1000, -16385));
    pending_items.push_back(mk(2000, 0, 1000, -1000, -1000, 1000, 1000, 0));
    pending_items.push_back(mk(2000, 0, 1001, -1000, -1000, 1000, 1000, 0));
    pending_items.push_back(mk(0, 0, 10, -1000, -1000, 1000, 1000, 8192));
    pending_items.push_back(mk(300, 300, 8388607, 300, 300, 300, 300, 12345));
    pending_items.push_back(mk(8388607, 8388607, 100, -8388608, -8388608,
                               -8388607, -8388607, -8192));
    pending_items.push_back(mk(-8388608, -8388608, 100, 8388606, 8388606,
                               8388607, 8388607, 24576));
    for (int i = 0; i < N_RANDOM; i++) pending_items.push_back(random_item());
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && !item_if.valid && expected_dist.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && expected_dist.size() == 0) begin
      $display("PASS circle_rotated_rect_distance_core");
    end else begin
      $display("FAIL circle_rotated_rect_distance_core");
    end
    $finish;
  end
endmodule
